### rtl/rsa_pkg.sv
// Shared types and constants for the refcounted slot allocator.
package rsa_pkg;

  localparam int unsigned SlotCount  = 32;
  localparam int unsigned ProgramMax = 16;
  localparam int unsigned SlotW      = $clog2(SlotCount);
  localparam int unsigned ProgW      = $clog2(ProgramMax);
  localparam int unsigned RefW       = 16;
  localparam logic [RefW-1:0] RefMax = '1;

  typedef enum logic [1:0] {
    REQ_BIND   = 2'd0,
    REQ_UNBIND = 2'd1,
    REQ_LOAD   = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_FREE     = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_NO_SLOT  = 3'd3,
    ST_HELD     = 3'd4,
    ST_RELEASED = 3'd5,
    ST_UNMAPPED = 3'd6,
    ST_STORED   = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_FREE,
    S_EVICT,
    S_EVCHK,
    S_WRITE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] object_id;
    logic [3:0]  list_index;
  } req_t;

  typedef struct packed {
    logic [4:0]  slot;
    logic [2:0]  status;
    logic [31:0] evicted_id;
  } rsp_t;

endpackage

### rtl/refcounted_slot_allocator_top.sv
// Top level of the refcounted slot allocator: sequencer around the slot id memory.
//
// channel | dir | handshake           | payload
// req     | in  | req_valid_i/ready_o | req_i (req_t)
// rsp     | out | rsp_valid_o/ready_i | rsp_o (rsp_t)
// cfg     | in  | cfg_we_i            | cfg_wdata_i (slot_limit)
//
// Bind and unbind scan slots 1..31 through the id memory, one read a cycle, then write
// once.
// A bind miss adds a free scan of up to limit-1 slots (valid bits in flops), an eviction
// scan that reads and then checks each slot, and a commit. Load and no-op answer
// in the cycle after the accept.
// Reset empties all slots at once through the valid bits; no clearing pass.
// A result waits in the output register; the next item is taken the cycle after it leaves.
module refcounted_slot_allocator_top
  import rsa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output rsp_t       rsp_o
);

  logic [31:0]        ids_mem [SlotCount];
  logic [31:0]        prog_mem [ProgramMax];
  logic [SlotCount-1:0] valid_q, valid_d;
  logic [RefW-1:0]    ref_q [SlotCount];
  logic [5:0]         limit_q;
  logic [SlotW-1:0]   cursor_q, cursor_d;
  logic [ProgW:0]     plen_q, plen_d;

  state_e             state_q, state_d;
  req_t               req_q, req_d;
  logic [SlotW-1:0]   pos_q, pos_d, start_q, start_d;
  logic [SlotW:0]     cnt_q, cnt_d;
  logic [SlotW-1:0]   found_q, found_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;
  logic [31:0]        rd_q;
  logic [31:0]        old_q, old_d;

  logic [SlotW-1:0]   rd_addr;
  logic               wr_en;
  logic [SlotW-1:0]   wr_slot;
  logic               ref_we;
  logic [RefW-1:0]    ref_wv;
  logic [SlotW:0]     lim;
  logic [SlotW-1:0]   pos_nx;
  logic               in_prog;

  always_comb begin
    if (limit_q < 6'd2) lim = (SlotW+1)'(2);
    else if (limit_q > 6'(SlotCount)) lim = (SlotW+1)'(SlotCount);
    else lim = limit_q[SlotW:0];
  end

  always_comb begin
    if ({1'b0, pos_q} + 1'b1 >= lim) pos_nx = SlotW'(1);
    else pos_nx = pos_q + 1'b1;
  end

  always_comb begin
    in_prog = 1'b0;
    for (int a = 0; a < ProgramMax; a++) begin
      if ((ProgW+1)'(a) < plen_q && prog_mem[a] == rd_q) in_prog = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= ids_mem[rd_addr];
    if (wr_en) ids_mem[wr_slot] <= req_q.object_id;
    if (state_q == S_IDLE && req_valid_i && req_ready_o &&
        req_i.req_type == REQ_LOAD) begin
      prog_mem[req_i.list_index] <= req_i.object_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) ref_q[i] <= '0;
    end else if (ref_we) begin
      ref_q[wr_slot] <= ref_wv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      limit_q     <= 6'd32;
      cursor_q    <= SlotW'(1);
      plen_q      <= '0;
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cursor_q    <= cursor_d;
      plen_q      <= plen_d;
      rsp_valid_q <= rsp_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    pos_q   <= pos_d;
    start_q <= start_d;
    found_q <= found_d;
    rsp_q   <= rsp_d;
    old_q   <= old_d;
  end

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pos_d       = pos_q;
    start_d     = start_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    valid_d     = valid_q;
    cursor_d    = cursor_q;
    plen_d      = plen_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    old_d       = old_q;
    rd_addr     = pos_q;
    wr_en       = 1'b0;
    wr_slot     = found_q;
    ref_we      = 1'b0;
    ref_wv      = '0;

    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        rd_addr = SlotW'(1);
        if (req_valid_i && req_ready_o) begin
          req_d   = req_i;
          found_d = '0;
          pos_d   = SlotW'(1);
          cnt_d   = '0;
          case (req_i.req_type)
            REQ_BIND, REQ_UNBIND: state_d = S_LOOKUP;
            REQ_LOAD: begin
              plen_d      = {1'b0, req_i.list_index} + 1'b1;
              rsp_d       = '{slot: '0, status: ST_STORED, evicted_id: '0};
              rsp_valid_d = 1'b1;
            end
            default: begin
              rsp_d       = '{slot: '0, status: ST_UNMAPPED, evicted_id: '0};
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end
      // rd_q holds ids_mem[pos_q] read in the previous cycle
      S_LOOKUP: begin
        if (found_q == '0 && valid_q[pos_q] && rd_q == req_q.object_id)
          found_d = pos_q;
        pos_d   = pos_q + 1'b1;
        rd_addr = pos_q + 1'b1;
        if (pos_q == SlotW'(SlotCount - 1)) state_d = S_WRITE;
        if (pos_q == SlotW'(SlotCount - 1) && req_q.req_type == REQ_BIND &&
            !(found_q == '0 && valid_q[pos_q] && rd_q == req_q.object_id) &&
            found_q == '0) begin
          state_d = S_FREE;
          if (cursor_q == '0 || {1'b0, cursor_q} >= lim) begin
            start_d = SlotW'(1);
            pos_d   = SlotW'(1);
          end else begin
            start_d = cursor_q;
            pos_d   = cursor_q;
          end
        end
      end
      S_FREE: begin
        if (!valid_q[pos_q]) begin
          found_d = pos_q;
          state_d = S_WRITE;
        end else if (cnt_q + 1'b1 >= lim - 1'b1) begin
          cnt_d    = '0;
          cursor_d = start_q;
          pos_d    = (({1'b0, start_q} + 1'b1) >= lim) ? SlotW'(1) : start_q + 1'b1;
          state_d  = S_EVICT;
        end else begin
          cnt_d = cnt_q + 1'b1;
          pos_d = pos_nx;
        end
      end
      S_EVICT: begin
        rd_addr = pos_q;
        state_d = S_EVCHK;
      end
      S_EVCHK: begin
        if (!in_prog) begin
          found_d = pos_q;
          old_d   = rd_q;
          state_d = S_OUT;
        end else if (cnt_q + 1'b1 >= lim - 1'b1) begin
          rsp_d       = '{slot: '0, status: ST_NO_SLOT, evicted_id: '0};
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          pos_d   = pos_nx;
          state_d = S_EVICT;
        end
      end
      S_WRITE: begin
        wr_slot = found_q;
        state_d = S_IDLE;
        rsp_valid_d = 1'b1;
        if (req_q.req_type == REQ_BIND) begin
          rsp_d = '{slot: found_q, status: ST_HIT, evicted_id: '0};
          ref_we = 1'b1;
          ref_wv = (ref_q[found_q] == RefMax) ? RefMax : ref_q[found_q] + 1'b1;
          if (!valid_q[found_q]) begin
            wr_en    = 1'b1;
            valid_d[found_q] = 1'b1;
            ref_wv   = RefW'(1);
            cursor_d = found_q;
            rsp_d    = '{slot: found_q, status: ST_FREE, evicted_id: '0};
          end
        end else if (found_q == '0) begin
          rsp_d = '{slot: '0, status: ST_UNMAPPED, evicted_id: '0};
        end else if (ref_q[found_q] <= RefW'(1)) begin
          ref_we           = 1'b1;
          ref_wv           = '0;
          valid_d[found_q] = 1'b0;
          cursor_d         = found_q;
          rsp_d = '{slot: found_q, status: ST_RELEASED, evicted_id: '0};
        end else begin
          ref_we = 1'b1;
          ref_wv = ref_q[found_q] - 1'b1;
          rsp_d  = '{slot: found_q, status: ST_HELD, evicted_id: '0};
        end
      end
      S_OUT: begin
        // eviction commit
        wr_slot          = found_q;
        wr_en            = 1'b1;
        ref_we           = 1'b1;
        ref_wv           = RefW'(1);
        valid_d[found_q] = 1'b1;
        cursor_d         = found_q;
        rsp_d = '{slot: found_q, status: ST_EVICTED, evicted_id: old_q};
        rsp_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_slot0_free: assert property (@(posedge clk_i) disable iff (!rst_ni) !valid_q[0])
    else $error("slot zero became valid");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("item accepted while busy");
  a_rsp_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == ST_FREE || rsp_o.status == ST_EVICTED))
      |-> rsp_o.slot != '0)
    else $error("allocation reported slot zero");
  a_ev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_EVICTED) |-> rsp_o.evicted_id == '0)
    else $error("evicted id set on non-eviction");
`endif

endmodule

### tb/sv/tb.sv
// Testbench for the refcounted slot allocator: queued driver, monitor, in-line predictor.
`timescale 1ns / 1ps
module tb;
  import rsa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [5:0] cfg_wdata_i = '0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  refcounted_slot_allocator_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
  );

  // predictor state
  logic [31:0] tbl_id [SlotCount];
  logic        tbl_vld [SlotCount];
  logic [15:0] tbl_cnt [SlotCount];
  logic [4:0]  cursor;
  logic [31:0] prog_list [ProgramMax];
  int unsigned prog_len;
  int unsigned limit_reg;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [31:0] bound_ids[$];
  int unsigned n_sent, n_rcvd, n_err, n_status[8];
  int unsigned idle_cycles;
  bit calm;
  int src_gap, snk_gap;

  initial forever #5 clk_i = ~clk_i;

  function automatic bit in_prog(logic [31:0] id);
    for (int a = 0; a < prog_len && a < ProgramMax; a++)
      if (prog_list[a] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic rsp_t allocate(req_t r);
    int unsigned lim, s, start, pos;
    rsp_t o;
    lim = limit_reg < 2 ? 2 : (limit_reg > SlotCount ? SlotCount : limit_reg);
    o = '0;
    s = 0;
    if (r.req_type == REQ_BIND || r.req_type == REQ_UNBIND)
      for (int i = SlotCount - 1; i >= 1; i--)
        if (tbl_vld[i] && tbl_id[i] == r.object_id) s = i;
    case (req_e'(r.req_type))
      REQ_BIND: begin
        if (s != 0) begin
          if (tbl_cnt[s] != RefMax) tbl_cnt[s]++;
          o.slot = 5'(s); o.status = ST_HIT;
          return o;
        end
        start = (cursor == 0 || cursor >= lim) ? 1 : cursor;
        pos = start;
        for (int k = 0; k < lim - 1; k++) begin
          if (!tbl_vld[pos]) begin
            tbl_vld[pos] = 1'b1; tbl_id[pos] = r.object_id; tbl_cnt[pos] = 16'd1;
            cursor = 5'(pos); o.slot = 5'(pos); o.status = ST_FREE;
            return o;
          end
          pos = (pos + 1 >= lim) ? 1 : pos + 1;
        end
        cursor = 5'(start);
        pos = start;
        for (int k = 0; k < lim - 1; k++) begin
          pos = (pos + 1 >= lim) ? 1 : pos + 1;
          if (!in_prog(tbl_id[pos])) begin
            o.evicted_id = tbl_id[pos];
            tbl_id[pos] = r.object_id; tbl_vld[pos] = 1'b1; tbl_cnt[pos] = 16'd1;
            cursor = 5'(pos); o.slot = 5'(pos); o.status = ST_EVICTED;
            return o;
          end
        end
        o.status = ST_NO_SLOT;
      end
      REQ_UNBIND: begin
        if (s == 0) o.status = ST_UNMAPPED;
        else if (tbl_cnt[s] <= 1) begin
          tbl_cnt[s] = '0; tbl_vld[s] = 1'b0; cursor = 5'(s);
          o.slot = 5'(s); o.status = ST_RELEASED;
        end else begin
          tbl_cnt[s]--; o.slot = 5'(s); o.status = ST_HELD;
        end
      end
      REQ_LOAD: begin
        prog_list[r.list_index] = r.object_id;
        prog_len = r.list_index + 1;
        o.status = ST_STORED;
      end
      default: o.status = ST_UNMAPPED;
    endcase
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      expected_rsps.push_back(allocate(req_i));
      n_sent++;
    end
    if (!req_valid_i || req_ready_o) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        req_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_i <= pending_reqs.pop_front();
        req_valid_i <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 17);
      end else req_valid_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rsp_valid_o && rsp_ready_i) begin
      rsp_t e;
      n_rcvd++;
      if (expected_rsps.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected beat %p", rsp_o);
      end else begin
        e = expected_rsps.pop_front();
        n_status[e.status]++;
        if (rsp_o.slot !== e.slot || rsp_o.status !== e.status ||
            rsp_o.evicted_id !== e.evicted_id) begin
          n_err++;
          if (n_err <= 10) $display("mismatch exp %p got %p", e, rsp_o);
        end
      end
    end
    if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) snk_gap <= $urandom_range(1, 17);
    end
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2: return $urandom();
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic add(req_e t, logic [31:0] id, logic [3:0] ix);
    req_t r;
    r.req_type = t; r.object_id = id; r.list_index = ix;
    pending_reqs.push_back(r);
    if (t == REQ_BIND) bound_ids.push_back(id);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req_valid_i && expected_rsps.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 6'(v);
    limit_reg = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int n, int max_ix);
    req_e t;
    logic [31:0] id;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: t = REQ_BIND;
        4, 5, 6: t = REQ_UNBIND;
        7, 8: t = REQ_LOAD;
        default: t = REQ_NOP;
      endcase
      id = (t == REQ_UNBIND && bound_ids.size() > 0 && $urandom_range(0, 3) != 0) ?
           bound_ids[$urandom_range(0, bound_ids.size() - 1)] : pick_id();
      // never extend the list past what was written
      add(t, id, 4'($urandom_range(0, max_ix)));
    end
  endtask

  initial begin
    limit_reg = 32;
    cursor = 1;
    prog_len = 0;
    foreach (tbl_vld[i]) begin
      tbl_vld[i] = 0; tbl_cnt[i] = 0; tbl_id[i] = 0;
    end
    src_gap = 0; snk_gap = 0; calm = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_limit(3);
    // write every list entry once before any list length can cover it
    for (int i = 0; i < ProgramMax; i++) add(REQ_LOAD, 32'h8000_0000 + 32'(i), 4'(i));
    // directed: fill, evict, protect, no slot, unbind paths
    add(REQ_UNBIND, 32'h5, 4'd0);
    add(REQ_BIND, 32'hFFFF_FFFF, 4'd0);
    add(REQ_BIND, 32'h0, 4'd0);
    add(REQ_BIND, 32'hFFFF_FFFF, 4'd0);
    add(REQ_LOAD, 32'hFFFF_FFFF, 4'd0);
    add(REQ_BIND, 32'h7, 4'd0);
    add(REQ_LOAD, 32'h7, 4'd1);
    add(REQ_BIND, 32'h9, 4'd0);
    add(REQ_NOP, 32'h9, 4'd15);
    add(REQ_UNBIND, 32'hFFFF_FFFF, 4'd0);
    add(REQ_UNBIND, 32'hFFFF_FFFF, 4'd0);
    add(REQ_LOAD, 32'hA5A5_5A5A, 4'd15);
    add(REQ_UNBIND, 32'h7, 4'd0);
    drain();
    write_limit(0);
    add(REQ_BIND, 32'h1234_5678, 4'd0);
    add(REQ_BIND, 32'h1234_5679, 4'd0);
    drain();
    // 63 clamps to the full table
    write_limit(63);
    random_phase(500, 15);
    drain();
    write_limit(2);
    random_phase(200, 15);
    drain();
    write_limit(6);
    random_phase(500, 15);
    drain();
    write_limit(32);
    random_phase(200, 15);
    calm = 1;
    random_phase(130, 15);
    drain();
    $display("sent %0d requests, checked %0d responses; hits %0d free %0d evict %0d",
             n_sent, n_rcvd, n_status[0], n_status[1], n_status[2]);
    $display("no-slot %0d held %0d released %0d unmapped %0d stored %0d",
             n_status[3], n_status[4], n_status[5], n_status[6], n_status[7]);
    if (n_err == 0 && expected_rsps.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

### files.f
rtl/rsa_pkg.sv
rtl/refcounted_slot_allocator_top.sv
tb/sv/tb.sv
